@@ design/fur_pkg.sv @@
// firmware upgrade receiver: shared types, codes and beat layouts
// no dependencies; imported by every module of the block
`default_nettype none

package fur_pkg;

    localparam int IN_DATA_W  = 272;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 72;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [1:0] REQ_INFO = 2'd0;
    localparam logic [1:0] REQ_DATA = 2'd1;
    localparam logic [1:0] REQ_END  = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_OVERSIZE  = 3'd1;
    localparam logic [2:0] ST_BAD_PARAM = 3'd2;
    localparam logic [2:0] ST_FLASH_ERR = 3'd3;
    localparam logic [2:0] ST_INDEX_ERR = 3'd4;
    localparam logic [2:0] ST_WRONG_LEN = 3'd5;

    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_ERASE = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SERIAL_CRC = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HWID_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HWID_HIGH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BYTES = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_PACK    = 3'd5;

    localparam logic [15:0] FULL_PACK_RESET = 16'd1024;

    typedef enum logic [1:0] {
        K_NONE,
        K_INFO,
        K_DATA,
        K_END
    } t_kind;

    typedef struct packed {
        logic [15:0] serial_crc;
        logic [63:0] hwid_low;
        logic [63:0] hwid_high;
        logic [31:0] region_base;
        logic [31:0] region_bytes;
        logic [15:0] full_pack;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic        ack;
        logic [2:0]  info_st;
        logic [31:0] erase_addr;
        logic [31:0] erase_len;
        logic [31:0] image_bytes;
        logic [31:0] pack_number;
        logic [15:0] pack_bytes;
        logic        flash_pass;
    } t_cls;

    typedef struct packed {
        logic empty;
        logic full;
        logic [1:0] count;
    } t_qstat;

endpackage

`default_nettype wire

@@ design/firmware_upgrade_receiver_unit.sv @@
// firmware upgrade receiver top level: configuration registers, front end, queue, back end
// depends on fur_pkg, fur_front, fur_queue, fur_back
`default_nettype none

// Takes one decoded upgrade packet per beat and returns exactly one result beat.
// A packet is taken every cycle while the queue is not full. Classification is
// combinational, the packet waits in a two-entry queue and the back end registers
// the state update and result. While the result register is stalled the queue
// still takes up to two more packets. Configuration registers must be written by
// the user through the plain write port only while idle; the block does not enforce it.
module firmware_upgrade_receiver_unit import fur_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    // want_ack, serial_crc, hwid_low, hwid_high, image_bytes, erase_len,
    // encrypted, pack_number, pack_bytes, flash_pass, zero pad
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,
    // req_type, is_reply
    input  wire logic [IN_USER_W-1:0]  i_s_tuser,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // send_ack, status_code, flash_cmd, flash_addr, flash_len, upgrade_done, zero pad
    output logic [OUT_DATA_W-1:0]      o_m_tdata
);

    t_cfg   r_cfg;
    t_cls   cls;
    t_cls   head;
    t_qstat qstat;
    logic   push;
    logic   pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.serial_crc   <= 16'd0;
            r_cfg.hwid_low     <= 64'd0;
            r_cfg.hwid_high    <= 64'd0;
            r_cfg.region_base  <= 32'd0;
            r_cfg.region_bytes <= 32'd0;
            r_cfg.full_pack    <= FULL_PACK_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SERIAL_CRC:   r_cfg.serial_crc   <= i_cfg_wdata[15:0];
                CFG_HWID_LOW:     r_cfg.hwid_low     <= i_cfg_wdata;
                CFG_HWID_HIGH:    r_cfg.hwid_high    <= i_cfg_wdata;
                CFG_REGION_BASE:  r_cfg.region_base  <= i_cfg_wdata[31:0];
                CFG_REGION_BYTES: r_cfg.region_bytes <= i_cfg_wdata[31:0];
                CFG_FULL_PACK:    r_cfg.full_pack    <= i_cfg_wdata[15:0];
                default:          r_cfg.full_pack    <= r_cfg.full_pack;
            endcase
        end
    end

    assign o_s_tready = !qstat.full;
    assign push       = i_s_tvalid && o_s_tready;

    fur_front u_front (
        .i_tdata (i_s_tdata),
        .i_tuser (i_s_tuser),
        .i_cfg   (r_cfg),
        .o_cls   (cls)
    );

    fur_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cls   (cls),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (qstat)
    );

    fur_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_head   (head),
        .i_qstat  (qstat),
        .o_pop    (pop),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata)
    );

    a_idle_cmd_no_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[5:4] == CMD_NONE) |-> (o_m_tdata[69:6] == 64'd0))
        else $error("flash fields set without a flash command");

    a_flash_err_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[3:1] == ST_FLASH_ERR) |-> (o_m_tdata[5:4] != CMD_NONE))
        else $error("flash error reported without a flash command");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (qstat.count != 2'd3) && (!qstat.full || !o_s_tready))
        else $error("queue occupancy out of range");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !qstat.empty)
        else $error("back end took an entry from an empty queue");

endmodule

`default_nettype wire

@@ design/fur_front.sv @@
// firmware upgrade receiver front end: unpacks a packet beat and classifies it
// depends on fur_pkg
`default_nettype none

module fur_front import fur_pkg::*; (
    input  wire logic [IN_DATA_W-1:0] i_tdata,
    input  wire logic [IN_USER_W-1:0] i_tuser,
    input  wire t_cfg                 i_cfg,
    output t_cls                      o_cls
);

    logic [1:0]  req_type;
    logic        is_reply;
    logic        want_ack;
    logic [15:0] serial_crc;
    logic [63:0] hwid_low;
    logic [63:0] hwid_high;
    logic [31:0] image_bytes;
    logic [31:0] erase_len;
    logic [7:0]  encrypted;
    logic        crc_match;
    logic        id_match;

    assign req_type    = i_tuser[1:0];
    assign is_reply    = i_tuser[2];
    assign want_ack    = i_tdata[0];
    assign serial_crc  = i_tdata[16:1];
    assign hwid_low    = i_tdata[80:17];
    assign hwid_high   = i_tdata[144:81];
    assign image_bytes = i_tdata[176:145];
    assign erase_len   = i_tdata[208:177];
    assign encrypted   = i_tdata[216:209];

    assign crc_match = (serial_crc == i_cfg.serial_crc);
    assign id_match  = (hwid_low == i_cfg.hwid_low) && (hwid_high == i_cfg.hwid_high);

    always_comb begin
        o_cls.kind = K_NONE;
        if (!is_reply) begin
            case (req_type)
                REQ_INFO: if (id_match || crc_match) o_cls.kind = K_INFO;
                REQ_DATA: if (crc_match) o_cls.kind = K_DATA;
                REQ_END:  if (crc_match) o_cls.kind = K_END;
                default:  o_cls.kind = K_NONE;
            endcase
        end

        if (image_bytes > i_cfg.region_bytes || erase_len > i_cfg.region_bytes) begin
            o_cls.info_st = ST_OVERSIZE;
        end else if (encrypted != 8'd0) begin
            o_cls.info_st = ST_BAD_PARAM;
        end else begin
            o_cls.info_st = ST_OK;
        end

        o_cls.ack         = want_ack;
        o_cls.erase_addr  = i_cfg.region_base;
        o_cls.erase_len   = (erase_len != 32'd0) ? erase_len : i_cfg.region_bytes;
        o_cls.image_bytes = image_bytes;
        o_cls.pack_number = i_tdata[248:217];
        o_cls.pack_bytes  = i_tdata[264:249];
        o_cls.flash_pass  = i_tdata[265];
    end

endmodule

`default_nettype wire

@@ design/fur_queue.sv @@
// firmware upgrade receiver: two-entry queue of classified packets
// depends on fur_pkg
`default_nettype none

module fur_queue import fur_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cls i_cls,
    input  wire logic i_pop,
    output t_cls      o_head,
    output t_qstat    o_stat
);

    t_cls       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cls;
        end
    end

    assign o_head       = r_mem[r_rd];
    assign o_stat.count = r_count;
    assign o_stat.empty = (r_count == 2'd0);
    assign o_stat.full  = (r_count == 2'd2);

endmodule

`default_nettype wire

@@ design/fur_back.sv @@
// firmware upgrade receiver back end: transfer state, flash commands, result register
// depends on fur_pkg
`default_nettype none

module fur_back import fur_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cfg                  i_cfg,
    input  wire t_cls                  i_head,
    input  wire t_qstat                i_qstat,
    output logic                       o_pop,
    output logic                       o_tvalid,
    input  wire logic                  i_tready,
    output logic [OUT_DATA_W-1:0]      o_tdata
);

    typedef enum logic [1:0] {
        PH_WAIT_INFO = 2'd0,
        PH_TRANSFER  = 2'd1,
        PH_WAIT_END  = 2'd2
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [31:0] r_exp, n_exp;
    logic [31:0] r_off, n_off;
    logic [31:0] r_img, n_img;
    logic        r_end, n_end;
    logic        r_valid;

    logic        r_ack, n_ack;
    logic [2:0]  r_st, n_st;
    logic [1:0]  r_cmd, n_cmd;
    logic [31:0] r_addr, n_addr;
    logic [31:0] r_len, n_len;

    logic [31:0] remain;
    logic [31:0] new_off;
    logic [31:0] wr_addr;

    assign o_pop   = !i_qstat.empty && (!r_valid || i_tready);
    assign remain  = r_img - r_off;
    assign new_off = r_off + {16'd0, i_head.pack_bytes};
    assign wr_addr = i_cfg.region_base + r_off;

    always_comb begin
        n_phase = r_phase;
        n_exp   = r_exp;
        n_off   = r_off;
        n_img   = r_img;
        n_end   = r_end;
        n_ack   = 1'b0;
        n_st    = ST_OK;
        n_cmd   = CMD_NONE;
        n_addr  = 32'd0;
        n_len   = 32'd0;
        case (i_head.kind)
            K_INFO: begin
                n_ack = i_head.ack;
                if (i_head.info_st != ST_OK) begin
                    n_st = i_head.info_st;
                end else begin
                    n_cmd  = CMD_ERASE;
                    n_addr = i_head.erase_addr;
                    n_len  = i_head.erase_len;
                    if (!i_head.flash_pass) begin
                        n_st = ST_FLASH_ERR;
                    end else begin
                        n_exp   = 32'd0;
                        n_img   = i_head.image_bytes;
                        n_off   = 32'd0;
                        n_end   = 1'b0;
                        n_phase = PH_TRANSFER;
                    end
                end
            end
            K_DATA: begin
                n_ack = i_head.ack;
                if (r_exp < i_head.pack_number || r_phase != PH_TRANSFER) begin
                    n_st = ST_INDEX_ERR;
                end else if (remain > {16'd0, i_cfg.full_pack} &&
                             i_head.pack_bytes != i_cfg.full_pack) begin
                    n_st = ST_WRONG_LEN;
                end else if (i_head.pack_number == r_exp) begin
                    n_cmd  = CMD_WRITE;
                    n_addr = wr_addr;
                    n_len  = {16'd0, i_head.pack_bytes};
                    if (!i_head.flash_pass) begin
                        n_st = ST_FLASH_ERR;
                    end else begin
                        n_off = new_off;
                        n_exp = r_exp + 32'd1;
                        if (new_off >= r_img) begin
                            n_phase = PH_WAIT_END;
                        end
                    end
                end
            end
            K_END: begin
                n_ack = i_head.ack;
                if (r_phase != PH_WAIT_END) begin
                    n_st = ST_INDEX_ERR;
                end else begin
                    n_end = 1'b1;
                end
            end
            default: begin
                n_ack = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT_INFO;
            r_exp   <= 32'd0;
            r_off   <= 32'd0;
            r_img   <= 32'd0;
            r_end   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase <= n_phase;
                r_exp   <= n_exp;
                r_off   <= n_off;
                r_img   <= n_img;
                r_end   <= n_end;
                r_valid <= 1'b1;
            end else if (i_tready) begin
                r_valid <= 1'b0;
            end
        end
        if (o_pop) begin
            r_ack  <= n_ack;
            r_st   <= n_st;
            r_cmd  <= n_cmd;
            r_addr <= n_addr;
            r_len  <= n_len;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = {1'b0, r_end, r_len, r_addr, r_cmd, r_st, r_ack};

endmodule

`default_nettype wire
